// File: design/ftcf_pkg.sv
// Shared types and constants for the force-torque calibration filter.
package ftcf_pkg;

    localparam int AXES       = 6;
    localparam int OUT_W      = 32;
    localparam int ACC_W      = 48;
    localparam int ALPHA_W    = 16;
    localparam int CNT_W      = 16;
    localparam int GAUGE_W    = 16;
    localparam int ROM_W      = 12;

    typedef logic signed [OUT_W-1:0] word_t;
    typedef logic signed [ACC_W-1:0] acc_t;

    // Calibration matrix entry for sensor s (wraps modulo two), axis a, gauge j.
    function automatic logic signed [ROM_W-1:0] cal_coef(
        input logic       s,
        input logic [2:0] a,
        input logic [2:0] j
    );
        logic signed [ROM_W-1:0] v;
        begin
            v = '0;
            case ({s, a, j})
                7'o000: v = -1;   7'o001: v = 0;    7'o002: v = -30;
                7'o003: v = 583;  7'o004: v = 23;   7'o005: v = -585;
                7'o010: v = 9;    7'o011: v = -683; 7'o012: v = -8;
                7'o013: v = 333;  7'o014: v = -15;  7'o015: v = 347;
                7'o020: v = -869; 7'o021: v = -21;  7'o022: v = -797;
                7'o023: v = 14;   7'o024: v = -972; 7'o025: v = 48;
                7'o030: v = -1;   7'o031: v = -10;  7'o032: v = 19;
                7'o033: v = 4;    7'o034: v = -20;  7'o035: v = 6;
                7'o040: v = -22;  7'o041: v = 0;    7'o042: v = 11;
                7'o043: v = -8;   7'o044: v = 11;   7'o045: v = 8;
                7'o050: v = 0;    7'o051: v = 10;   7'o052: v = 0;
                7'o053: v = 10;   7'o054: v = 0;    7'o055: v = 10;
                7'o100: v = 5;    7'o101: v = -3;   7'o102: v = -71;
                7'o103: v = 591;  7'o104: v = 69;   7'o105: v = -600;
                7'o110: v = 87;   7'o111: v = -688; 7'o112: v = -24;
                7'o113: v = 335;  7'o114: v = -65;  7'o115: v = 352;
                7'o120: v = -869; 7'o121: v = -61;  7'o122: v = -847;
                7'o123: v = -67;  7'o124: v = -902; 7'o125: v = -55;
                7'o130: v = 1;    7'o131: v = -10;  7'o132: v = 19;
                7'o133: v = 6;    7'o134: v = -20;  7'o135: v = 4;
                7'o140: v = -22;  7'o141: v = -2;   7'o142: v = 12;
                7'o143: v = -7;   7'o144: v = 10;   7'o145: v = 9;
                7'o150: v = -1;   7'o151: v = 10;   7'o152: v = -1;
                7'o153: v = 10;   7'o154: v = -1;   7'o155: v = 10;
                default: v = '0;
            endcase
            return v;
        end
    endfunction

    // Saturate a wide signed value to 32 bits.
    function automatic word_t sat32(input logic signed [ACC_W:0] v);
        begin
            if (v > $signed({{(ACC_W-OUT_W+1){1'b0}}, {1'b0, {(OUT_W-1){1'b1}}}}))
                return {1'b0, {(OUT_W-1){1'b1}}};
            else if (v < $signed({{(ACC_W-OUT_W+1){1'b1}}, {1'b1, {(OUT_W-1){1'b0}}}}))
                return {1'b1, {(OUT_W-1){1'b0}}};
            else
                return v[OUT_W-1:0];
        end
    endfunction

endpackage

// File: design/ftcf_divider.sv
// Bit-serial restoring divider for the rounded bias mean.
module ftcf_divider (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [ftcf_pkg::ACC_W-1:0] dividend,
    input  logic [ftcf_pkg::CNT_W-1:0] divisor,
    output logic                      done,
    output logic [ftcf_pkg::ACC_W-1:0] quotient
);
    import ftcf_pkg::*;

    localparam int STEP_W = $clog2(ACC_W + 1);

    logic [ACC_W-1:0]  quot_reg;
    logic [CNT_W:0]    rem_reg;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;
    logic [CNT_W-1:0]  div_reg;
    logic [CNT_W:0]    trial;

    // One quotient bit per cycle, most significant first.
    assign trial = {rem_reg[CNT_W-1:0], quot_reg[ACC_W-1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(ACC_W);
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quot_reg <= dividend;
            rem_reg  <= '0;
            div_reg  <= divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, div_reg})
            begin
                rem_reg  <= trial - {1'b0, div_reg};
                quot_reg <= {quot_reg[ACC_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= trial;
                quot_reg <= {quot_reg[ACC_W-2:0], 1'b0};
            end
        end
    end

    assign quotient = quot_reg;
endmodule

// File: design/force_torque_calib_filter_core.sv
// Top level: six-axis calibration matrix, bias averaging and low-pass filter.
// Per axis a sample beat runs six 16-bit serial products and a rounding step; the
// low-pass filter then runs axis by axis. While calibrating, a beat adds to the bias sums
// instead; the closing beat divides each sum by the count (zero bias with no samples).
// One item at a time; a start beat leaves the core idle and ready for the next beat.
// Reset clears alpha to 1285, all biases, sums, filter outputs and phases.
module force_torque_calib_filter_core #(
    parameter int SENSORS = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        op,
    input  logic        sensor,
    input  logic signed [15:0] gauge_0,
    input  logic signed [15:0] gauge_1,
    input  logic signed [15:0] gauge_2,
    input  logic signed [15:0] gauge_3,
    input  logic signed [15:0] gauge_4,
    input  logic signed [15:0] gauge_5,
    input  logic [15:0] bias_samples,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        which_sensor,
    output logic signed [31:0] force_x,
    output logic signed [31:0] force_y,
    output logic signed [31:0] force_z,
    output logic signed [31:0] torque_x,
    output logic signed [31:0] torque_y,
    output logic signed [31:0] torque_z,
    output logic        calibrating
);
    import ftcf_pkg::*;

    localparam int NSLOT = SENSORS * AXES;
    localparam int SL_W  = (NSLOT > 1) ? $clog2(NSLOT) : 1;
    localparam int SS_W  = (SENSORS > 1) ? $clog2(SENSORS) : 1;

    typedef enum logic [2:0] {
        S_IDLE, S_MAC, S_ROUND, S_BIAS, S_DIV, S_FILT, S_OUT
    } state_t;

    state_t state_reg;
    logic [ALPHA_W-1:0] alpha_reg;
    word_t bias_reg [NSLOT];
    acc_t  sum_reg  [NSLOT];
    word_t filt_reg [NSLOT];
    logic  act_reg  [SENSORS];
    logic [CNT_W-1:0] cnt_reg [SENSORS];
    logic [CNT_W-1:0] tgt_reg [SENSORS];

    logic signed [GAUGE_W-1:0] g_reg [AXES];
    logic        sen_reg;
    logic [2:0]  axis_reg;
    logic [2:0]  gi_reg;
    logic [4:0]  bit_reg;
    logic [GAUGE_W-1:0] mshift_reg;
    logic signed [ACC_W:0] acc_reg;
    logic signed [ACC_W:0] mcand_reg;
    word_t x_reg [AXES];
    logic  held_reg;
    logic  div_start;
    logic  div_done;
    logic [ACC_W-1:0] div_q;
    logic [ACC_W-1:0] mag;
    logic [SL_W-1:0] slot;
    logic signed [ACC_W:0] round_v;
    logic signed [ACC_W:0] d_v;
    logic signed [ACC_W:0] filt_v;

    assign slot = SL_W'(sen_reg) * SL_W'(AXES) + SL_W'(axis_reg);
    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE);

    // Magnitude of the sum for the divider.
    assign mag = sum_reg[slot][ACC_W-1] ? ACC_W'(-sum_reg[slot]) : sum_reg[slot];
    assign round_v = (acc_reg + (ACC_W+1)'(8)) >>> 4;
    assign d_v = (ACC_W+1)'(sat32((ACC_W+1)'($signed(x_reg[axis_reg])) -
                                  (ACC_W+1)'($signed(bias_reg[slot]))));
    assign filt_v = d_v - (ACC_W+1)'($signed(filt_reg[slot]));

    ftcf_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (mag + ACC_W'(tgt_reg[sen_reg] >> 1)),
        .divisor  (tgt_reg[sen_reg]),
        .done     (div_done),
        .quotient (div_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            alpha_reg <= ALPHA_W'(1285);
            out_valid <= 1'b0;
            div_start <= 1'b0;
            for (int i = 0; i < NSLOT; i++)
            begin
                bias_reg[i] <= '0;
                sum_reg[i]  <= '0;
                filt_reg[i] <= '0;
            end
            for (int i = 0; i < SENSORS; i++)
            begin
                act_reg[i] <= 1'b0;
                cnt_reg[i] <= '0;
                tgt_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_valid) alpha_reg <= cfg_data;
            case (state_reg)
                S_IDLE:
                begin
                    div_start <= 1'b0;
                    if (in_valid)
                    begin
                        if (op)
                        begin
                            for (int i = 0; i < NSLOT; i++) sum_reg[i] <= '0;
                            for (int i = 0; i < SENSORS; i++)
                            begin
                                act_reg[i] <= 1'b1;
                                cnt_reg[i] <= '0;
                                tgt_reg[i] <= bias_samples;
                            end
                        end
                        else if (32'(sensor) < 32'(SENSORS))
                        begin
                            g_reg[0] <= gauge_0; g_reg[1] <= gauge_1; g_reg[2] <= gauge_2;
                            g_reg[3] <= gauge_3; g_reg[4] <= gauge_4; g_reg[5] <= gauge_5;
                            sen_reg    <= sensor;
                            axis_reg   <= '0;
                            gi_reg     <= '0;
                            bit_reg    <= '0;
                            acc_reg    <= '0;
                            mshift_reg <= gauge_0;
                            mcand_reg  <= (ACC_W+1)'(cal_coef(sensor, 3'd0, 3'd0));
                            state_reg  <= S_MAC;
                        end
                    end
                end
                // Shift-add multiply: one gauge bit per cycle, sign bit subtracts.
                S_MAC:
                begin
                    div_start <= 1'b0;
                    if (mshift_reg[0])
                    begin
                        if (bit_reg == 5'(GAUGE_W-1))
                            acc_reg <= acc_reg - mcand_reg;
                        else
                            acc_reg <= acc_reg + mcand_reg;
                    end
                    if (bit_reg == 5'(GAUGE_W-1))
                    begin
                        bit_reg <= '0;
                        if (gi_reg == 3'(AXES-1))
                            state_reg <= S_ROUND;
                        else
                        begin
                            gi_reg     <= gi_reg + 1'b1;
                            mshift_reg <= g_reg[gi_reg + 1'b1];
                            mcand_reg  <= (ACC_W+1)'(cal_coef(sen_reg, axis_reg,
                                                             gi_reg + 1'b1));
                        end
                    end
                    else
                    begin
                        mshift_reg <= mshift_reg >> 1;
                        mcand_reg  <= mcand_reg <<< 1;
                        bit_reg    <= bit_reg + 1'b1;
                    end
                end
                S_ROUND:
                begin
                    x_reg[axis_reg] <= sat32(round_v);
                    acc_reg <= '0;
                    gi_reg  <= '0;
                    if (axis_reg == 3'(AXES-1))
                    begin
                        axis_reg <= '0;
                        held_reg <= act_reg[SS_W'(sen_reg)];
                        if (!act_reg[SS_W'(sen_reg)])
                        begin
                            state_reg <= S_FILT;
                            div_start <= 1'b0;
                        end
                        else if (cnt_reg[SS_W'(sen_reg)] < tgt_reg[SS_W'(sen_reg)])
                        begin
                            state_reg <= S_BIAS;
                            div_start <= 1'b0;
                        end
                        else
                        begin
                            act_reg[SS_W'(sen_reg)] <= 1'b0;
                            state_reg <= S_DIV;
                            div_start <= 1'b1;
                        end
                    end
                    else
                    begin
                        axis_reg   <= axis_reg + 1'b1;
                        mshift_reg <= g_reg[0];
                        mcand_reg  <= (ACC_W+1)'(cal_coef(sen_reg, axis_reg + 1'b1, 3'd0));
                        state_reg  <= S_MAC;
                        div_start  <= 1'b0;
                    end
                end
                // Accumulate one axis per cycle.
                S_BIAS:
                begin
                    div_start <= 1'b0;
                    sum_reg[slot] <= sum_reg[slot] + ACC_W'($signed(x_reg[axis_reg]));
                    if (axis_reg == 3'(AXES-1))
                    begin
                        cnt_reg[SS_W'(sen_reg)] <= cnt_reg[SS_W'(sen_reg)] + 1'b1;
                        state_reg <= S_OUT;
                        out_valid <= 1'b1;
                    end
                    else
                        axis_reg <= axis_reg + 1'b1;
                end
                S_DIV:
                begin
                    if (div_done || tgt_reg[SS_W'(sen_reg)] == '0)
                    begin
                        if (tgt_reg[SS_W'(sen_reg)] == '0)
                            bias_reg[slot] <= '0;
                        else if (sum_reg[slot][ACC_W-1])
                            bias_reg[slot] <= sat32(-$signed({1'b0, div_q}));
                        else
                            bias_reg[slot] <= sat32($signed({1'b0, div_q}));
                        if (axis_reg == 3'(AXES-1))
                        begin
                            state_reg <= S_OUT;
                            out_valid <= 1'b1;
                            div_start <= 1'b0;
                        end
                        else
                        begin
                            axis_reg  <= axis_reg + 1'b1;
                            div_start <= 1'b1;
                        end
                    end
                    else
                        div_start <= 1'b0;
                end
                // Filter: shift-add alpha times error, one alpha bit per cycle.
                S_FILT:
                begin
                    div_start <= 1'b0;
                    if (bit_reg == 5'd0)
                    begin
                        mcand_reg  <= filt_v;
                        mshift_reg <= alpha_reg;
                        acc_reg    <= (ACC_W+1)'(32768);
                        bit_reg    <= 5'd1;
                    end
                    else if (bit_reg <= 5'(ALPHA_W))
                    begin
                        if (mshift_reg[0]) acc_reg <= acc_reg + mcand_reg;
                        mshift_reg <= mshift_reg >> 1;
                        mcand_reg  <= mcand_reg <<< 1;
                        bit_reg    <= bit_reg + 1'b1;
                    end
                    else
                    begin
                        filt_reg[slot] <= sat32((ACC_W+1)'($signed(filt_reg[slot])) +
                                                (acc_reg >>> ALPHA_W));
                        bit_reg <= '0;
                        if (axis_reg == 3'(AXES-1))
                        begin
                            state_reg <= S_OUT;
                            out_valid <= 1'b1;
                        end
                        else
                            axis_reg <= axis_reg + 1'b1;
                    end
                end
                S_OUT:
                begin
                    div_start <= 1'b0;
                    if (out_ready)
                    begin
                        out_valid <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    div_start <= 1'b0;
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Result fields read the held filter outputs of the current sensor.
    assign which_sensor = sen_reg;
    assign calibrating  = held_reg;
    assign force_x  = filt_reg[SL_W'(sen_reg) * SL_W'(AXES) + SL_W'(0)];
    assign force_y  = filt_reg[SL_W'(sen_reg) * SL_W'(AXES) + SL_W'(1)];
    assign force_z  = filt_reg[SL_W'(sen_reg) * SL_W'(AXES) + SL_W'(2)];
    assign torque_x = filt_reg[SL_W'(sen_reg) * SL_W'(AXES) + SL_W'(3)];
    assign torque_y = filt_reg[SL_W'(sen_reg) * SL_W'(AXES) + SL_W'(4)];
    assign torque_z = filt_reg[SL_W'(sen_reg) * SL_W'(AXES) + SL_W'(5)];
endmodule
